### rtl/rwoc_pkg.sv
// rwoc_pkg: shared widths, stream layout, register indexes and object classes
// for the range window object classifier; no dependencies
package rwoc_pkg;

  // fixed field widths
  localparam int RANGE_W             = 13;
  localparam int CLUSTER_W           = 2;
  localparam int SENSOR_W            = 2;
  localparam int PAT_W               = 3;
  localparam int CLASS_W             = 3;
  localparam int SENSORS_PER_CLUSTER = 3;

  // stream and configuration port widths
  localparam int S_TDATA_W  = 24;
  localparam int M_TDATA_W  = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic [RANGE_W-1:0] NEAR_LIMIT_RST = 13'h0000;
  localparam logic [RANGE_W-1:0] FAR_LIMIT_RST  = 13'h1fff;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEAR_LIMIT = 1'b0,
    CFG_FAR_LIMIT  = 1'b1
  } cfg_reg_e;

  // object classes
  typedef enum logic [CLASS_W-1:0] {
    CLS_AIR  = 3'd0,
    CLS_CUP  = 3'd1,
    CLS_TREE = 3'd2,
    CLS_NET  = 3'd3,
    CLS_NONE = 3'd4
  } class_e;

  // detect patterns, bit n is sensor n
  localparam logic [PAT_W-1:0] PAT_AIR  = 3'b000;
  localparam logic [PAT_W-1:0] PAT_CUP  = 3'b101;
  localparam logic [PAT_W-1:0] PAT_TREE = 3'b010;
  localparam logic [PAT_W-1:0] PAT_NET  = 3'b111;

  // result of the update stage
  typedef struct packed {
    logic             hit;
    logic [PAT_W-1:0] pattern;
    class_e           cls;
  } cls_res_t;

  function automatic class_e class_of(logic [PAT_W-1:0] pat);
    class_e c;
    case (pat)
      PAT_AIR:  c = CLS_AIR;
      PAT_CUP:  c = CLS_CUP;
      PAT_TREE: c = CLS_TREE;
      PAT_NET:  c = CLS_NET;
      default:  c = CLS_NONE;
    endcase
    return c;
  endfunction

endpackage

### rtl/rwoc_ram.sv
// rwoc_ram: simple dual-port RAM, one write and one registered read per cycle
// depends on nothing
module rwoc_ram #(
  parameter int unsigned DEPTH = 96,
  parameter int unsigned DW    = 13,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  // write port and registered read port, read returns the old contents
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/rwoc_recip_div.sv
// rwoc_recip_div: divides a range sample by a constant window length through
// a reciprocal multiply and shift; uses rwoc_pkg
module rwoc_recip_div #(
  parameter int unsigned DIVISOR = 8
) (
  input  logic [rwoc_pkg::RANGE_W-1:0] range_i,
  output logic [rwoc_pkg::RANGE_W-1:0] quot_o
);

  // m = ceil(2^(N+l) / d) with l = ceil(log2 d) is exact for N-bit dividends
  localparam int unsigned L     = $clog2(DIVISOR);
  localparam int unsigned SH    = rwoc_pkg::RANGE_W + L;
  localparam int unsigned MW    = rwoc_pkg::RANGE_W + 1;
  localparam int unsigned PRODW = rwoc_pkg::RANGE_W + MW;
  localparam longint unsigned MULT_L = ((64'd1 << SH) + DIVISOR - 1) / DIVISOR;
  localparam logic [MW-1:0] MULT = MW'(MULT_L);

  logic [PRODW-1:0] prod;

  assign prod   = PRODW'(range_i) * PRODW'(MULT);
  assign quot_o = rwoc_pkg::RANGE_W'(prod >> SH);

endmodule

### rtl/rwoc_classify.sv
// rwoc_classify: band test of the new window sum, cluster pattern update and
// object class lookup; uses rwoc_pkg
module rwoc_classify (
  input  logic [rwoc_pkg::RANGE_W-1:0]   sum_i,
  input  logic [rwoc_pkg::RANGE_W-1:0]   near_i,
  input  logic [rwoc_pkg::RANGE_W-1:0]   far_i,
  input  logic [rwoc_pkg::PAT_W-1:0]     row_i,
  input  logic [rwoc_pkg::SENSOR_W-1:0]  sensor_i,
  input  logic                           cluster_ok_i,
  input  logic                           sensor_ok_i,
  output rwoc_pkg::cls_res_t             res_o
);

  logic                         hit;
  logic [rwoc_pkg::PAT_W-1:0]   row_new;

  // strict band test, only for a sensor that is updated
  assign hit = cluster_ok_i && sensor_ok_i && (sum_i > near_i) && (sum_i < far_i);

  // replace the updated sensor's flag in the cluster row
  always_comb begin
    row_new = row_i;
    if (sensor_ok_i) begin
      row_new[sensor_i] = hit;
    end
  end

  // pattern and class, out-of-range cluster reports no match
  always_comb begin
    res_o.hit = hit;
    if (cluster_ok_i) begin
      res_o.pattern = row_new;
      res_o.cls     = rwoc_pkg::class_of(row_new);
    end else begin
      res_o.pattern = '0;
      res_o.cls     = rwoc_pkg::CLS_NONE;
    end
  end

endmodule

### rtl/range_window_object_classifier.sv
// range_window_object_classifier: top level with the three-stage update
// pipeline and both state RAMs; uses rwoc_pkg, rwoc_ram, rwoc_recip_div and
// rwoc_classify
// One item per cycle while no held result stalls the pipeline.
// The accept edge reads the sensor-state RAM into stage A, stage A reads the
// window RAM into stage B, and stage B updates the sum, flags and RAMs and
// loads the result register; a held result stalls every stage behind it.
// Reset clears pipeline valids, limits (0 and 8191), detect flags and the
// per-sensor touched and window-full flags; RAM contents are masked by those
// flags, so no clearing pass runs and items are taken right after reset.
module range_window_object_classifier #(
  parameter int unsigned NUM_CLUSTERS = 4,
  parameter int unsigned WINDOW_LEN   = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // cfg port
  input  logic                              cfg_we_i,
  input  logic [rwoc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rwoc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input stream
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [1:0] cluster_id, [3:2] sensor_id, [16:4] range_mm, [23:17] zero
  input  logic [rwoc_pkg::S_TDATA_W-1:0]    s_axis_tdata_i,
  // result stream
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [1:0] cluster_out, [2] sensor_hit, [5:3] cluster_pattern,
  // [8:6] object_class, [15:9] zero
  output logic [rwoc_pkg::M_TDATA_W-1:0]    m_axis_tdata_o
);

  localparam int unsigned SPC = rwoc_pkg::SENSORS_PER_CLUSTER;
  localparam int unsigned NS  = NUM_CLUSTERS * SPC;
  localparam int unsigned SIW = $clog2(NS);
  localparam int unsigned CIW = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;
  localparam int unsigned PW  = $clog2(WINDOW_LEN);
  localparam int unsigned WD  = NS * WINDOW_LEN;
  localparam int unsigned AW  = $clog2(WD);
  localparam int unsigned RW  = rwoc_pkg::RANGE_W;
  localparam int unsigned STW = PW + RW;

  typedef struct packed {
    logic [PW-1:0] pos;
    logic [RW-1:0] sum;
  } st_t;

  // limits
  logic [RW-1:0] near_q, far_q;

  // per-sensor flags and per-cluster detect rows
  logic [NS-1:0]                touched_q;
  logic [NS-1:0]                full_q;
  logic [rwoc_pkg::PAT_W-1:0]   hit_row_q [NUM_CLUSTERS];

  // handshake
  logic o_free, b_adv, a_adv, in_acc;

  // input decode
  logic [rwoc_pkg::CLUSTER_W-1:0] in_cl;
  logic [rwoc_pkg::SENSOR_W-1:0]  in_sn;
  logic [RW-1:0]                  in_range;
  logic [RW-1:0]                  in_v;
  logic                           in_cok, in_sok;
  logic [CIW-1:0]                 in_cidx;
  logic [SIW-1:0]                 in_sidx;
  logic                           z_fwd;

  // stage A
  logic                           a_vld_q;
  logic [rwoc_pkg::CLUSTER_W-1:0] a_cl_q;
  logic [rwoc_pkg::SENSOR_W-1:0]  a_sn_q;
  logic                           a_cok_q, a_sok_q;
  logic [CIW-1:0]                 a_cidx_q;
  logic [SIW-1:0]                 a_sidx_q;
  logic [RW-1:0]                  a_v_q;
  logic                           a_zfwd_q, a_tch_q;
  st_t                            a_z_q;
  logic [STW-1:0]                 st_raw;
  st_t                            a_st;
  logic [PW-1:0]                  a_pos_n;
  logic [AW-1:0]                  a_waddr;

  // stage B
  logic                           b_vld_q;
  logic [rwoc_pkg::CLUSTER_W-1:0] b_cl_q;
  logic [rwoc_pkg::SENSOR_W-1:0]  b_sn_q;
  logic                           b_cok_q, b_sok_q;
  logic [CIW-1:0]                 b_cidx_q;
  logic [SIW-1:0]                 b_sidx_q;
  logic [RW-1:0]                  b_v_q;
  logic [PW-1:0]                  b_pos_q;
  logic [RW-1:0]                  b_sum_q;
  logic [AW-1:0]                  b_waddr_q;
  logic [RW-1:0]                  win_raw;
  logic [RW-1:0]                  b_old;
  logic [RW-1:0]                  b_sum_n;
  st_t                            b_st_n;
  logic                           b_upd;
  rwoc_pkg::cls_res_t             cls_res;

  // result register
  logic                           o_vld_q;
  logic [rwoc_pkg::M_TDATA_W-1:0] o_data_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q <= rwoc_pkg::NEAR_LIMIT_RST;
      far_q  <= rwoc_pkg::FAR_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (rwoc_pkg::cfg_reg_e'(cfg_idx_i))
        rwoc_pkg::CFG_NEAR_LIMIT: near_q <= RW'(cfg_data_i);
        rwoc_pkg::CFG_FAR_LIMIT:  far_q  <= RW'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign o_free          = !o_vld_q || m_axis_tready_i;
  assign b_adv           = b_vld_q && o_free;
  assign a_adv           = a_vld_q && (!b_vld_q || b_adv);
  assign s_axis_tready_o = !a_vld_q || a_adv;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // input field decode and sensor index
  assign in_cl    = s_axis_tdata_i[1:0];
  assign in_sn    = s_axis_tdata_i[3:2];
  assign in_range = s_axis_tdata_i[16:4];
  assign in_cok   = int'(in_cl) < NUM_CLUSTERS;
  assign in_sok   = int'(in_sn) < SPC;
  assign in_cidx  = CIW'(in_cl);
  assign in_sidx  = (in_cok && in_sok) ? SIW'(int'(in_cidx) * SPC + int'(in_sn)) : '0;

  rwoc_recip_div #(
    .DIVISOR (WINDOW_LEN)
  ) u_div (
    .range_i (in_range),
    .quot_o  (in_v)
  );

  // the item leaving stage B writes state the RAM read below cannot see yet
  assign z_fwd = b_adv && b_upd && (b_sidx_q == in_sidx);

  // stage A registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (in_acc) begin
      a_vld_q <= 1'b1;
    end else if (a_adv) begin
      a_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_cl_q   <= in_cl;
      a_sn_q   <= in_sn;
      a_cok_q  <= in_cok;
      a_sok_q  <= in_sok;
      a_cidx_q <= in_cidx;
      a_sidx_q <= in_sidx;
      a_v_q    <= in_v;
      a_zfwd_q <= z_fwd;
      a_z_q    <= b_st_n;
      a_tch_q  <= touched_q[in_sidx];
    end
  end

  // sensor state: ring position and running sum
  rwoc_ram #(
    .DEPTH (NS),
    .DW    (STW)
  ) u_st_ram (
    .clk_i   (clk_i),
    .we_i    (b_adv && b_upd),
    .waddr_i (b_sidx_q),
    .wdata_i (b_st_n),
    .re_i    (in_acc),
    .raddr_i (in_sidx),
    .rdata_o (st_raw)
  );

  // stage A current state, newest copy first
  always_comb begin
    if (b_vld_q && b_upd && (b_sidx_q == a_sidx_q)) begin
      a_st = b_st_n;
    end else if (a_zfwd_q) begin
      a_st = a_z_q;
    end else if (a_tch_q) begin
      a_st = st_t'(st_raw);
    end else begin
      a_st = '0;
    end
  end

  // next ring position and its window address
  assign a_pos_n = (int'(a_st.pos) == WINDOW_LEN - 1) ? '0 : PW'(a_st.pos + 1'b1);
  assign a_waddr = AW'(int'(a_sidx_q) * WINDOW_LEN + int'(a_pos_n));

  // stage B registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (a_adv) begin
      b_vld_q <= 1'b1;
    end else if (b_adv) begin
      b_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      b_cl_q    <= a_cl_q;
      b_sn_q    <= a_sn_q;
      b_cok_q   <= a_cok_q;
      b_sok_q   <= a_sok_q;
      b_cidx_q  <= a_cidx_q;
      b_sidx_q  <= a_sidx_q;
      b_v_q     <= a_v_q;
      b_pos_q   <= a_pos_n;
      b_sum_q   <= a_st.sum;
      b_waddr_q <= a_waddr;
    end
  end

  // sample windows, all sensors back to back
  rwoc_ram #(
    .DEPTH (WD),
    .DW    (RW)
  ) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (b_adv && b_upd),
    .waddr_i (b_waddr_q),
    .wdata_i (b_v_q),
    .re_i    (a_adv),
    .raddr_i (a_waddr),
    .rdata_o (win_raw)
  );

  // running sum update, unwritten window entries count as zero
  assign b_upd   = b_cok_q && b_sok_q;
  assign b_old   = full_q[b_sidx_q] ? win_raw : '0;
  assign b_sum_n = RW'(b_sum_q + b_v_q - b_old);
  assign b_st_n  = '{pos: b_pos_q, sum: b_sum_n};

  rwoc_classify u_cls (
    .sum_i        (b_sum_n),
    .near_i       (near_q),
    .far_i        (far_q),
    .row_i        (hit_row_q[b_cidx_q]),
    .sensor_i     (b_sn_q),
    .cluster_ok_i (b_cok_q),
    .sensor_ok_i  (b_sok_q),
    .res_o        (cls_res)
  );

  // per-sensor flags and detect rows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touched_q <= '0;
      full_q    <= '0;
      for (int c = 0; c < NUM_CLUSTERS; c++) begin
        hit_row_q[c] <= '0;
      end
    end else if (b_adv && b_upd) begin
      touched_q[b_sidx_q] <= 1'b1;
      if (b_pos_q == '0) begin
        full_q[b_sidx_q] <= 1'b1;
      end
      hit_row_q[b_cidx_q] <= cls_res.pattern;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (b_adv) begin
      o_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      o_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      o_data_q <= {7'd0, cls_res.cls, cls_res.pattern, cls_res.hit, b_cl_q};
    end
  end

  assign m_axis_tvalid_o = o_vld_q;
  assign m_axis_tdata_o  = o_data_q;

  // an accepted item always lands in stage A
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> a_vld_q)
    else $error("accepted item missing from stage A");

  // a stalled stage B item stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_vld_q && !b_adv) |=> (b_vld_q && $stable(b_sidx_q) && $stable(b_pos_q)))
    else $error("stage B item changed while stalled");

  // a full window belongs to a sensor whose state was written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_vld_q && b_upd && full_q[b_sidx_q]) |-> touched_q[b_sidx_q])
    else $error("window full flag set on untouched sensor");

  // an item that updates nothing never reports a hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_vld_q && !b_upd) |-> !cls_res.hit)
    else $error("hit reported for out-of-range sensor");

endmodule

### tb/rwoc_result_checker.sv
`timescale 1ns / 100ps
// rwoc_result_checker: watches the config port and both streams of the range
// window object classifier, predicts every report and compares it; uses rwoc_pkg
module rwoc_result_checker #(
  parameter int unsigned NUM_CLUSTERS = 4,
  parameter int unsigned WINDOW_LEN   = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rwoc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rwoc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            s_axis_tvalid_i,
  input  logic                            s_axis_tready_i,
  // [1:0] cluster_id, [3:2] sensor_id, [16:4] range_mm, [23:17] zero
  input  logic [rwoc_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                            m_axis_tvalid_i,
  input  logic                            m_axis_tready_i,
  // [1:0] cluster_out, [2] sensor_hit, [5:3] cluster_pattern,
  // [8:6] object_class, [15:9] zero
  input  logic [rwoc_pkg::M_TDATA_W-1:0]  m_axis_tdata_i,
  output int unsigned                     fail_cnt_o,
  output int unsigned                     pending_o,
  output int unsigned                     checked_o
);
  import rwoc_pkg::*;

  localparam int unsigned NUM_SENSORS = NUM_CLUSTERS * SENSORS_PER_CLUSTER;
  localparam int unsigned HIT_LSB     = CLUSTER_W;
  localparam int unsigned PAT_LSB     = CLUSTER_W + 1;
  localparam int unsigned CLASS_LSB   = PAT_LSB + PAT_W;
  localparam int unsigned PAD_LSB     = CLASS_LSB + CLASS_W;

  typedef struct packed {
    logic [CLUSTER_W-1:0] cluster;
    logic                 hit;
    logic [PAT_W-1:0]     pattern;
    class_e               cls;
  } report_t;

  // model copy of limits and per-sensor windows
  logic [RANGE_W-1:0] near_lim;
  logic [RANGE_W-1:0] far_lim;
  logic [RANGE_W-1:0] win_mem [NUM_SENSORS][WINDOW_LEN];
  logic [RANGE_W-1:0] win_sum [NUM_SENSORS];
  int unsigned        win_pos [NUM_SENSORS];
  logic               det_flag [NUM_SENSORS];
  report_t            due_reports [$];
  int unsigned        fail_cnt = 0;
  int unsigned        checked_cnt = 0;

  // pattern to object class
  function automatic class_e pattern_class(logic [PAT_W-1:0] pat);
    class_e c;
    c = CLS_NONE;
    if (pat == PAT_AIR) c = CLS_AIR;
    else if (pat == PAT_CUP) c = CLS_CUP;
    else if (pat == PAT_TREE) c = CLS_TREE;
    else if (pat == PAT_NET) c = CLS_NET;
    return c;
  endfunction

  // push one sample into its sensor window and form the cluster report
  function automatic report_t take_sample(logic [CLUSTER_W-1:0] c,
                                          logic [SENSOR_W-1:0] s,
                                          logic [RANGE_W-1:0] r);
    report_t            rep;
    int unsigned        idx;
    int unsigned        nxt;
    logic [RANGE_W-1:0] avg;
    logic [PAT_W-1:0]   pat;
    rep.cluster = c;
    rep.hit     = 1'b0;
    rep.pattern = '0;
    rep.cls     = CLS_NONE;
    if (c < NUM_CLUSTERS) begin
      if (s < SENSORS_PER_CLUSTER) begin
        idx = c * SENSORS_PER_CLUSTER + s;
        avg = r / WINDOW_LEN;
        nxt = (win_pos[idx] + 1) % WINDOW_LEN;
        // 13-bit running sum, oldest entry drops out
        win_sum[idx]      = win_sum[idx] + avg - win_mem[idx][nxt];
        win_mem[idx][nxt] = avg;
        win_pos[idx]      = nxt;
        det_flag[idx]     = (win_sum[idx] > near_lim) && (win_sum[idx] < far_lim);
        rep.hit           = det_flag[idx];
      end
      for (int k = 0; k < SENSORS_PER_CLUSTER; k++) begin
        pat[k] = det_flag[c * SENSORS_PER_CLUSTER + k];
      end
      rep.pattern = pat;
      rep.cls     = pattern_class(pat);
    end
    return rep;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      fail_cnt++;
      $display("%0t ns: mismatch on %s, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    report_t want;
    if (!rst_ni) begin
      near_lim = NEAR_LIMIT_RST;
      far_lim  = FAR_LIMIT_RST;
      for (int i = 0; i < NUM_SENSORS; i++) begin
        for (int j = 0; j < WINDOW_LEN; j++) win_mem[i][j] = '0;
        win_sum[i]  = '0;
        win_pos[i]  = 0;
        det_flag[i] = 1'b0;
      end
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NEAR_LIMIT: near_lim = cfg_data_i;
          CFG_FAR_LIMIT:  far_lim  = cfg_data_i;
          default: ;
        endcase
      end
      // accepted sample
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        due_reports.push_back(take_sample(s_axis_tdata_i[CLUSTER_W-1:0],
                                          s_axis_tdata_i[CLUSTER_W +: SENSOR_W],
                                          s_axis_tdata_i[CLUSTER_W+SENSOR_W +: RANGE_W]));
      end
      // accepted report
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (due_reports.size() == 0) begin
          fail_cnt++;
          $display("%0t ns: report with none expected, expected nothing, actual %h",
                   $time, m_axis_tdata_i);
        end else begin
          want = due_reports.pop_front();
          checked_cnt++;
          check_field("cluster_out", want.cluster, m_axis_tdata_i[CLUSTER_W-1:0]);
          check_field("sensor_hit", want.hit, m_axis_tdata_i[HIT_LSB]);
          check_field("cluster_pattern", want.pattern, m_axis_tdata_i[PAT_LSB +: PAT_W]);
          check_field("object_class", want.cls, m_axis_tdata_i[CLASS_LSB +: CLASS_W]);
          check_field("padding", 8'd0, m_axis_tdata_i[M_TDATA_W-1:PAD_LSB]);
        end
      end
    end
    fail_cnt_o <= fail_cnt;
    pending_o  <= due_reports.size();
    checked_o  <= checked_cnt;
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// testbench: drives samples and limit writes into the range window object
// classifier and gives the verdict; uses rwoc_pkg and rwoc_result_checker
module testbench;
  import rwoc_pkg::*;

  localparam int unsigned NUM_CLUSTERS    = 4;
  localparam int unsigned WINDOW_LEN      = 8;
  localparam int unsigned N_PHASES        = 10;
  localparam int unsigned ITEMS_PER_PHASE = 150;
  localparam int unsigned HOLD_CYCLES     = 64;
  localparam int unsigned PRESSURE_PHASE  = 3;
  localparam int unsigned PAUSE_PHASE     = 5;
  localparam int          RANGE_MAX       = (1 << RANGE_W) - 1;
  localparam int unsigned SENSOR_UNUSED   = (1 << SENSOR_W) - 1;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = CFG_NEAR_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  // [1:0] cluster_id, [3:2] sensor_id, [16:4] range_mm, [23:17] zero
  logic [S_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  // [1:0] cluster_out, [2] sensor_hit, [5:3] cluster_pattern,
  // [8:6] object_class, [15:9] zero
  logic [M_TDATA_W-1:0]  m_axis_tdata_o;

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned checked;

  // shared between sender and receiver, written with nonblocking assignments
  bit          no_idle = 1'b0;
  int unsigned hold_req = 0;

  // receiver state
  int unsigned hold_seen = 0;
  int unsigned rx_hold = 0;
  int unsigned rx_stall = 0;
  bit          rx_calm = 1'b0;

  // sender state
  bit          tx_calm = 1'b0;
  bit          tx_steady = 1'b0;
  int unsigned n_items = 0;
  int unsigned n_settings = 0;
  int          band_lo = 0;
  int          band_hi = RANGE_MAX;
  int          aim_mm [NUM_CLUSTERS][SENSORS_PER_CLUSTER];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  range_window_object_classifier #(
    .NUM_CLUSTERS (NUM_CLUSTERS),
    .WINDOW_LEN   (WINDOW_LEN)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  rwoc_result_checker #(
    .NUM_CLUSTERS (NUM_CLUSTERS),
    .WINDOW_LEN   (WINDOW_LEN)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .fail_cnt_o      (fail_cnt),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  // result side: random stall bursts, calm stretches and one long hold-off
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      rx_hold   = HOLD_CYCLES;
    end
    if (rx_hold != 0) begin
      rx_hold--;
      m_axis_tready_i <= 1'b0;
    end else if (no_idle || rx_calm) begin
      m_axis_tready_i <= 1'b1;
    end else if (rx_stall != 0) begin
      rx_stall--;
      m_axis_tready_i <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      rx_stall = $urandom_range(0, 6);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
    if ($urandom_range(0, 99) == 0) rx_calm = !rx_calm;
  end

  // offer one sample, with an optional idle burst ahead of it
  task automatic offer_sample(input logic [CLUSTER_W-1:0] c, input logic [SENSOR_W-1:0] s,
                              input logic [RANGE_W-1:0] r);
    int unsigned gap;
    if ($urandom_range(0, 79) == 0) tx_calm = !tx_calm;
    if (!no_idle && !tx_calm && !tx_steady && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(S_TDATA_W - CLUSTER_W - SENSOR_W - RANGE_W){1'b0}}, r, s, c};
    do @(posedge clk_i); while (!s_axis_tready_o);
    n_items++;
  endtask

  // stop offering and wait for every expected report
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_limits(input logic [RANGE_W-1:0] near_v, input logic [RANGE_W-1:0] far_v);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_NEAR_LIMIT;
    cfg_data_i <= near_v;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_FAR_LIMIT;
    cfg_data_i <= far_v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    n_settings++;
  endtask

  // mostly steady per-sensor distances with jitter, plus noise and extremes
  task automatic offer_random_sample();
    int unsigned roll;
    int unsigned c;
    int unsigned s;
    int          r;
    roll = $urandom_range(0, 99);
    c    = $urandom_range(0, NUM_CLUSTERS - 1);
    s    = $urandom_range(0, SENSORS_PER_CLUSTER - 1);
    if (roll < 5) begin
      s = SENSOR_UNUSED;
      r = $urandom_range(0, RANGE_MAX);
    end else if (roll < 12) begin
      r = $urandom_range(0, RANGE_MAX);
    end else if (roll < 16) begin
      r = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(RANGE_MAX - 15, RANGE_MAX);
    end else begin
      if ($urandom_range(0, 15) == 0) begin
        aim_mm[c][s] = $urandom_range(0, 1) ? $urandom_range(band_lo, band_hi)
                                            : $urandom_range(0, RANGE_MAX);
      end
      r = aim_mm[c][s] + $urandom_range(0, 64) - 32;
      if (r < 0) r = 0;
      else if (r > RANGE_MAX) r = RANGE_MAX;
    end
    offer_sample(c, s, r);
  endtask

  initial begin
    int near_v;
    int far_v;
    for (int c = 0; c < NUM_CLUSTERS; c++) begin
      for (int s = 0; s < SENSORS_PER_CLUSTER; s++) aim_mm[c][s] = $urandom_range(0, RANGE_MAX);
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset limits, zero and truncated samples, every class
    offer_sample(0, 0, 0);
    offer_sample(0, 0, 7);
    offer_sample(0, 0, 8);
    offer_sample(1, 0, RANGE_MAX);
    offer_sample(1, 2, RANGE_MAX);
    offer_sample(2, 1, RANGE_MAX);
    offer_sample(3, 0, RANGE_MAX);
    offer_sample(3, 1, RANGE_MAX);
    offer_sample(3, 2, RANGE_MAX);
    // sensor id past the cluster reports the pattern unchanged
    offer_sample(3, SENSOR_UNUSED, RANGE_MAX);
    offer_sample(0, SENSOR_UNUSED, 0);
    // inverted, equal and adjacent limits leave no band
    write_limits(RANGE_MAX, 0);
    offer_sample(3, 0, RANGE_MAX);
    offer_sample(1, 1, 4000);
    write_limits(1000, 1000);
    offer_sample(1, 0, 8000);
    offer_sample(2, 1, 1000);
    write_limits(0, 1);
    offer_sample(0, 0, 8);
    write_limits(RANGE_MAX - 1, RANGE_MAX);
    offer_sample(2, 2, RANGE_MAX);
    // band just around two full-scale samples
    write_limits(2045, 2047);
    offer_sample(1, 2, RANGE_MAX);
    offer_sample(1, 0, RANGE_MAX);

    // random phases, each with its own limits
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph == 0 ? 0 : $urandom_range(0, 5))
        0: begin near_v = 0; far_v = RANGE_MAX; end
        1: begin
          near_v = $urandom_range(0, 6000);
          far_v  = near_v + $urandom_range(1, 2000);
        end
        2: begin
          far_v  = $urandom_range(0, 6000);
          near_v = far_v + $urandom_range(0, 300);
        end
        3: begin
          near_v = $urandom_range(0, 8000);
          far_v  = near_v + $urandom_range(2, 20);
        end
        4: begin near_v = 0; far_v = $urandom_range(1, RANGE_MAX); end
        default: begin near_v = $urandom_range(0, RANGE_MAX - 1); far_v = RANGE_MAX; end
      endcase
      if (far_v > RANGE_MAX) far_v = RANGE_MAX;
      write_limits(near_v, far_v);
      // aim distances in the band where there is one
      if (far_v > near_v + 9) begin
        band_lo = near_v + 8;
        band_hi = far_v - 1;
      end else begin
        band_lo = 0;
        band_hi = RANGE_MAX;
      end
      if (ph == N_PHASES - 1) no_idle <= 1'b1;
      if (ph == PRESSURE_PHASE) begin
        hold_req <= hold_req + 1;
        tx_steady = 1'b1;
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (ph == PRESSURE_PHASE && i == 100) tx_steady = 1'b0;
        if (ph == PAUSE_PHASE && i == 70) wait_drained();
        offer_random_sample();
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("covered %0d samples under %0d limit settings, %0d reports checked",
             n_items, n_settings, checked);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
